// ----- rtl/core/fbfl_pkg.sv -----
`timescale 1ns / 1ps

package fbfl_pkg;

    // fixed field widths
    localparam int OFFSET_BITS = 24;
    localparam int SIZE_BITS   = 16;
    localparam int COUNT_BITS  = 8;
    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;
    localparam int STEP_BITS   = $clog2(OFFSET_BITS);

    // register index, taken from paddr above the byte lanes
    localparam logic REG_BLOCK_SIZE  = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REINIT = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_FREE  = 2'd1,
        STAT_OUTSIDE  = 2'd2,
        STAT_ALL_FREE = 2'd3
    } status_t;

    typedef struct packed {
        op_t                    operation;
        logic [OFFSET_BITS-1:0] byte_offset;
    } in_item_t;

    typedef struct packed {
        status_t                status;
        logic [COUNT_BITS-1:0]  block_index;
        logic [OFFSET_BITS-1:0] block_offset;
        logic [COUNT_BITS-1:0]  free_blocks;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ALLOC_RD,
        S_ALLOC_UPD,
        S_FREE_DIV,
        S_FREE_UPD,
        S_INIT_RUN,
        S_SEND
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic alloc_rd;
        logic alloc_upd;
        logic div_start;
        logic free_upd;
        logic init_step;
        logic res_plain;
        logic send;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic total_zero;
        logic div_done;
        logic init_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/core/fbfl_ram.sv -----
`timescale 1ns / 1ps

module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 255
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/fbfl_div.sv -----
`timescale 1ns / 1ps

module fbfl_div
    import fbfl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [OFFSET_BITS-1:0] dividend,
    input  logic [SIZE_BITS-1:0]   divisor,
    output logic                   done,
    output logic [OFFSET_BITS-1:0] quotient,
    output logic [SIZE_BITS-1:0]   remainder
);

    logic [OFFSET_BITS-1:0] quo_reg, quo_next;
    logic [SIZE_BITS-1:0]   rem_reg, rem_next;
    logic [SIZE_BITS-1:0]   dsr_reg, dsr_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [SIZE_BITS+1:0]   trial;
    logic                   fits;

    // one restoring step: shift in the next dividend bit and try the divisor
    assign trial = {1'b0, rem_reg, quo_reg[OFFSET_BITS-1]} - {2'b00, dsr_reg};
    assign fits  = ~trial[SIZE_BITS+1];

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[OFFSET_BITS-2:0], fits};
            rem_next  = fits ? trial[SIZE_BITS-1:0]
                             : {rem_reg[SIZE_BITS-2:0], quo_reg[OFFSET_BITS-1]};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_BITS'(OFFSET_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        step_reg <= step_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/core/fbfl_ctrl.sv -----
`timescale 1ns / 1ps

module fbfl_ctrl
    import fbfl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (stat.op)
                    OP_ALLOC:  state_next = stat.total_zero ? S_SEND : S_ALLOC_RD;
                    OP_FREE:   state_next = S_FREE_DIV;
                    OP_REINIT: state_next = S_INIT_RUN;
                    default:   state_next = S_SEND;
                endcase
            end
            S_ALLOC_RD:  state_next = S_ALLOC_UPD;
            S_ALLOC_UPD: state_next = S_SEND;
            S_FREE_DIV: begin
                if (stat.div_done) begin
                    state_next = S_FREE_UPD;
                end
            end
            S_FREE_UPD: state_next = S_SEND;
            S_INIT_RUN: begin
                if (stat.init_last) begin
                    state_next = S_SEND;
                end
            end
            S_SEND: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            S_DISPATCH: begin
                case (stat.op)
                    OP_ALLOC: begin
                        cmd.res_plain = stat.total_zero;
                        cmd.alloc_rd  = ~stat.total_zero;
                    end
                    OP_FREE:   cmd.div_start = 1'b1;
                    OP_REINIT: cmd.init_step = 1'b0;
                    default:   cmd.res_plain = 1'b1;
                endcase
            end
            S_ALLOC_RD:  cmd.alloc_rd  = 1'b1;
            S_ALLOC_UPD: cmd.alloc_upd = 1'b1;
            S_FREE_DIV:  cmd.div_start = 1'b0;
            S_FREE_UPD:  cmd.free_upd  = 1'b1;
            S_INIT_RUN: begin
                cmd.init_step = 1'b1;
                cmd.res_plain = stat.init_last;
            end
            S_SEND: cmd.send = stat.out_free;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/fbfl_dp.sv -----
`timescale 1ns / 1ps

module fbfl_dp
    import fbfl_pkg::*;
#(
    parameter int MAX_BLOCKS = 255
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  in_item_t              s_item,
    output out_item_t             m_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  logic [SIZE_BITS-1:0]  block_size,
    input  logic [COUNT_BITS-1:0] block_count,
    input  ctrl_cmd_t             cmd,
    output dp_stat_t              stat
);

    localparam int AW = $clog2(MAX_BLOCKS);

    op_t                    op_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [COUNT_BITS-1:0]  head_reg, head_next;
    logic [COUNT_BITS-1:0]  total_reg, total_next;
    logic [COUNT_BITS-1:0]  cnt_reg;
    logic [OFFSET_BITS-1:0] prod_reg;
    status_t                res_status_reg;
    logic [COUNT_BITS-1:0]  res_idx_reg;
    logic [OFFSET_BITS-1:0] res_boff_reg;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_item_reg;

    logic [SIZE_BITS-1:0]   eff_size;
    logic [COUNT_BITS-1:0]  eff_count;
    logic                   div_done;
    logic [OFFSET_BITS-1:0] quo;
    logic [SIZE_BITS-1:0]   rem;
    logic                   q_outside;
    logic                   all_free;
    logic                   head_in_store;
    logic                   init_wr;
    logic                   push;
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [COUNT_BITS-1:0]  ram_wr_data;
    logic [COUNT_BITS-1:0]  ram_rd_data;

    // zero size acts as one, count is capped at the store depth
    assign eff_size  = (block_size == '0) ? SIZE_BITS'(1) : block_size;
    assign eff_count = (block_count > COUNT_BITS'(MAX_BLOCKS)) ? COUNT_BITS'(MAX_BLOCKS)
                                                               : block_count;

    fbfl_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (off_reg),
        .divisor   (eff_size),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // free checks: offset test first, then full list
    assign q_outside = (quo[OFFSET_BITS-1:COUNT_BITS] != '0) ||
                       (quo[COUNT_BITS-1:0] >= eff_count);
    assign all_free  = total_reg >= eff_count;
    assign push      = cmd.free_upd && !q_outside && !all_free;

    assign head_in_store = head_reg < COUNT_BITS'(MAX_BLOCKS);

    // link store write: reinit sweep or push on free
    assign init_wr     = cmd.init_step && (cnt_reg < eff_count);
    assign ram_wr_en   = init_wr || push;
    assign ram_wr_addr = push ? quo[AW-1:0] : cnt_reg[AW-1:0];
    assign ram_wr_data = push ? head_reg : cnt_reg + 1'b1;

    fbfl_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_links (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.alloc_rd && head_in_store),
        .rd_addr (head_in_store ? head_reg[AW-1:0] : '0),
        .rd_data (ram_rd_data)
    );

    // list head and free count
    always_comb begin
        head_next  = head_reg;
        total_next = total_reg;
        if (cmd.alloc_upd) begin
            head_next  = head_in_store ? ram_rd_data : '0;
            total_next = total_reg - 1'b1;
        end else if (push) begin
            head_next  = quo[COUNT_BITS-1:0];
            total_next = total_reg + 1'b1;
        end else if (cmd.init_step && cmd.res_plain) begin
            head_next  = '0;
            total_next = eff_count;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.send) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // item capture, sweep counter, product and result fields
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg  <= s_item.operation;
            off_reg <= s_item.byte_offset;
            cnt_reg <= '0;
        end else if (cmd.init_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.alloc_rd) begin
            prod_reg <= OFFSET_BITS'(head_reg) * OFFSET_BITS'(eff_size);
        end
        if (cmd.res_plain) begin
            res_status_reg <= (op_reg == OP_ALLOC) ? STAT_NO_FREE : STAT_OK;
            res_idx_reg    <= '0;
            res_boff_reg   <= '0;
        end else if (cmd.alloc_upd) begin
            res_status_reg <= STAT_OK;
            res_idx_reg    <= head_reg;
            res_boff_reg   <= prod_reg;
        end else if (cmd.free_upd) begin
            // quotient times size is the offset less its remainder
            res_status_reg <= q_outside ? STAT_OUTSIDE :
                              all_free  ? STAT_ALL_FREE : STAT_OK;
            res_idx_reg    <= push ? quo[COUNT_BITS-1:0] : '0;
            res_boff_reg   <= push ? off_reg - OFFSET_BITS'(rem) : '0;
        end
        if (cmd.send) begin
            m_item_reg.status       <= res_status_reg;
            m_item_reg.block_index  <= res_idx_reg;
            m_item_reg.block_offset <= res_boff_reg;
            m_item_reg.free_blocks  <= total_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign stat.op         = op_reg;
    assign stat.total_zero = total_reg == '0;
    assign stat.div_done   = div_done;
    assign stat.init_last  = ({1'b0, cnt_reg} + 1'b1) >= {1'b0, eff_count};
    assign stat.out_free   = !m_valid_reg || m_ready;

endmodule

// ----- rtl/core/fixed_block_free_list_allocator_top.sv -----
`timescale 1ns / 1ps

// channel   | direction | handshake        | payload
// ----------+-----------+------------------+--------------------------------
// s_        | in        | s_valid/s_ready  | s_item  (in_item_t)
// m_        | out       | m_valid/m_ready  | m_item  (out_item_t)
// apb       | in        | psel/penable     | paddr, pwdata, prdata
//
// allocate reads the head from the link ram, then updates the head and free count
// free runs the restoring divider, one quotient bit per cycle
// reinitialise writes one link per cycle
// no clearing pass after reset; nothing is free until a reinitialise
// a new item is taken while the previous result waits in the output register

module fixed_block_free_list_allocator_top
    import fbfl_pkg::*;
#(
    parameter int MAX_BLOCKS = 255
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    logic [SIZE_BITS-1:0]  block_size_reg;
    logic [COUNT_BITS-1:0] block_count_reg;
    logic                  reg_sel;
    logic                  cfg_wr;
    ctrl_cmd_t             cmd;
    dp_stat_t              stat;

    // configuration registers
    assign reg_sel = paddr[PADDR_BITS-1];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg  <= SIZE_BITS'(1);
            block_count_reg <= COUNT_BITS'(255);
        end else if (cfg_wr) begin
            if (reg_sel == REG_BLOCK_SIZE) begin
                block_size_reg <= pwdata[SIZE_BITS-1:0];
            end else begin
                block_count_reg <= pwdata[COUNT_BITS-1:0];
            end
        end
    end

    assign prdata = (reg_sel == REG_BLOCK_COUNT) ? PDATA_BITS'(block_count_reg)
                                                 : PDATA_BITS'(block_size_reg);

    fbfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fbfl_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_item      (s_item),
        .m_item      (m_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .block_size  (block_size_reg),
        .block_count (block_count_reg),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ----- rtl/core/fbfl_checker.sv -----
`timescale 1ns / 1ps

module fbfl_checker
    import fbfl_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // an accepted item holds off the next one: s_ready is low in the cycle after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted in back to back cycles");

    // failed operations report no block
    a_fail_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status != STAT_OK) |->
            (m_item.block_index == '0) && (m_item.block_offset == '0))
        else $error("block reported on a failed operation");

    // allocation fails only on an empty list
    a_no_free_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == STAT_NO_FREE) |-> m_item.free_blocks == '0)
        else $error("no free block reported with blocks free");

    // a full list is never empty
    a_all_free_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == STAT_ALL_FREE) |-> m_item.free_blocks != '0)
        else $error("chunk all free reported with nothing free");

endmodule

bind fixed_block_free_list_allocator_top fbfl_checker u_fbfl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
